/* hw/rtl/tnrx_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// tnrx_pkg
// Byte codes, result kinds and the decoded-result struct shared by the
// telnet receive option refuser.
// ----------------------------------------------------------------------------
package tnrx_pkg;

    localparam logic [7:0] BYTE_IAC  = 8'd255;
    localparam logic [7:0] BYTE_WILL = 8'd251;
    localparam logic [7:0] BYTE_WONT = 8'd252;
    localparam logic [7:0] BYTE_DO   = 8'd253;
    localparam logic [7:0] BYTE_DONT = 8'd254;
    localparam logic [7:0] BYTE_CR   = 8'h0d;
    localparam logic [7:0] BYTE_NL   = 8'h0a;

    localparam int unsigned LEN_W = 12;
    localparam logic [LEN_W-1:0] MAX_LINE_LEN_RST = 12'd127;

    typedef enum logic [1:0] {
        KIND_DATA  = 2'd0,
        KIND_REPLY = 2'd1,
        KIND_TERM  = 2'd2
    } kind_t;

    // results caused by one input byte, in emission order b0, b1, b2
    typedef struct packed {
        logic [1:0]       cnt;
        kind_t            kind;
        logic [7:0]       b0;
        logic [7:0]       b1;
        logic [7:0]       b2;
        logic [LEN_W-1:0] len;
        logic             ovf;
    } res_t;

endpackage
`default_nettype wire

/* hw/rtl/telnet_rx_option_refuser.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// telnet_rx_option_refuser
// Telnet receive side: line data, CR handling, and refusal of every option.
// ----------------------------------------------------------------------------
// Received bytes enter an input register and are decoded combinationally
// into a result buffer of up to three beats. A byte that yields no result or
// one result is taken every cycle when m_ready stays high. An option byte
// yields a three-beat reply; the buffer drains one beat per cycle while
// m_ready is high, so a later byte that yields a result waits in the input
// register until the last reply beat is taken. cfg_ready is always high.
module telnet_rx_option_refuser (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       cfg_valid,
    output      logic                       cfg_ready,
    input  wire logic [tnrx_pkg::LEN_W-1:0] cfg_max_line_len,
    input  wire logic                       s_valid,
    output      logic                       s_ready,
    input  wire logic [7:0]                 s_rx_byte,
    output      logic                       m_valid,
    input  wire logic                       m_ready,
    output      logic [1:0]                 m_out_kind,
    output      logic [7:0]                 m_out_byte,
    output      logic [tnrx_pkg::LEN_W-1:0] m_line_len,
    output      logic                       m_overflow,
    output      logic                       m_last
);
    import tnrx_pkg::*;

    logic [LEN_W-1:0] max_len_reg;
    logic             in_vld_reg;
    logic [7:0]       in_byte_reg;
    logic [1:0]       res_cnt_reg;
    kind_t            res_kind_reg;
    logic [7:0]       res_b0_reg, res_b1_reg, res_b2_reg;
    logic [LEN_W-1:0] res_len_reg;
    logic             res_ovf_reg;

    res_t dec;
    logic buf_free, step, pop, load;

    tnrx_decode u_decode (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .step         (step),
        .rx_byte      (in_byte_reg),
        .max_line_len (max_len_reg),
        .res          (dec)
    );

    assign cfg_ready = 1'b1;
    assign m_valid   = (res_cnt_reg != 2'd0);
    assign pop       = m_valid && m_ready;
    assign buf_free  = (res_cnt_reg == 2'd0) || ((res_cnt_reg == 2'd1) && m_ready);
    assign step      = in_vld_reg && ((dec.cnt == 2'd0) || buf_free);
    assign load      = step && (dec.cnt != 2'd0);
    assign s_ready   = !in_vld_reg || step;

    assign m_out_kind = res_kind_reg;
    assign m_out_byte = res_b0_reg;
    assign m_line_len = res_len_reg;
    assign m_overflow = res_ovf_reg;
    assign m_last     = (res_cnt_reg == 2'd1);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_len_reg <= MAX_LINE_LEN_RST;
            in_vld_reg  <= 1'b0;
            res_cnt_reg <= 2'd0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                max_len_reg <= cfg_max_line_len;
            end
            if (s_ready) begin
                in_vld_reg <= s_valid;
            end
            priority if (load) begin
                res_cnt_reg <= dec.cnt;
            end else if (pop) begin
                res_cnt_reg <= res_cnt_reg - 2'd1;
            end else begin
                res_cnt_reg <= res_cnt_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_byte_reg <= s_rx_byte;
        end
        priority if (load) begin
            res_kind_reg <= dec.kind;
            res_b0_reg   <= dec.b0;
            res_b1_reg   <= dec.b1;
            res_b2_reg   <= dec.b2;
            res_len_reg  <= dec.len;
            res_ovf_reg  <= dec.ovf;
        end else if (pop) begin
            // advance to the next reply beat
            res_b0_reg <= res_b1_reg;
            res_b1_reg <= res_b2_reg;
        end else begin
            res_b0_reg <= res_b0_reg;
        end
    end

endmodule
`default_nettype wire

/* hw/rtl/tnrx_decode.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// tnrx_decode
// Telnet parse state and line bookkeeping; decodes one byte into its results
// and advances the state when the byte is consumed.
// ----------------------------------------------------------------------------
module tnrx_decode (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      step,
    input  wire logic [7:0]                rx_byte,
    input  wire logic [tnrx_pkg::LEN_W-1:0] max_line_len,
    output tnrx_pkg::res_t                 res
);
    import tnrx_pkg::*;

    typedef enum logic [2:0] {
        PS_NORMAL = 3'd0,
        PS_IAC    = 3'd1,
        PS_WILL   = 3'd2,
        PS_WONT   = 3'd3,
        PS_DO     = 3'd4,
        PS_DONT   = 3'd5,
        PS_CR     = 3'd6
    } ps_t;

    ps_t              state_reg, state_next;
    logic [LEN_W-1:0] count_reg, count_next;
    logic             ovf_reg, ovf_next;
    logic [LEN_W-1:0] count_plus1;
    logic             fits;

    assign count_plus1 = count_reg + LEN_W'(1);
    assign fits = ({1'b0, count_reg} + (LEN_W+1)'(1)) < {1'b0, max_line_len};

    always_comb begin
        state_next = PS_NORMAL;
        count_next = count_reg;
        ovf_next   = ovf_reg;
        res.cnt    = 2'd0;
        res.kind   = KIND_DATA;
        res.b0     = rx_byte;
        res.b1     = BYTE_IAC;
        res.b2     = BYTE_IAC;
        res.len    = count_reg;
        res.ovf    = ovf_reg;
        unique case (state_reg)
            PS_IAC: begin
                priority if (rx_byte == BYTE_IAC) begin
                    if (fits) begin
                        res.cnt    = 2'd1;
                        res.len    = count_plus1;
                        count_next = count_plus1;
                    end else begin
                        ovf_next = 1'b1;
                    end
                end else if (rx_byte == BYTE_WILL) begin
                    state_next = PS_WILL;
                end else if (rx_byte == BYTE_WONT) begin
                    state_next = PS_WONT;
                end else if (rx_byte == BYTE_DO) begin
                    state_next = PS_DO;
                end else if (rx_byte == BYTE_DONT) begin
                    state_next = PS_DONT;
                end else begin
                    state_next = PS_NORMAL;
                end
            end
            PS_WILL, PS_WONT: begin
                res.cnt  = 2'd3;
                res.kind = KIND_REPLY;
                res.b0   = BYTE_IAC;
                res.b1   = BYTE_DONT;
                res.b2   = rx_byte;
            end
            PS_DO, PS_DONT: begin
                res.cnt  = 2'd3;
                res.kind = KIND_REPLY;
                res.b0   = BYTE_IAC;
                res.b1   = BYTE_WONT;
                res.b2   = rx_byte;
            end
            PS_CR: begin
                res.cnt    = 2'd1;
                res.kind   = KIND_TERM;
                res.b0     = BYTE_NL;
                res.len    = count_plus1;
                count_next = '0;
                ovf_next   = 1'b0;
            end
            default: begin
                priority if (rx_byte == BYTE_IAC) begin
                    state_next = PS_IAC;
                end else if (rx_byte == BYTE_CR) begin
                    state_next = PS_CR;
                end else if (fits) begin
                    res.cnt    = 2'd1;
                    res.len    = count_plus1;
                    count_next = count_plus1;
                end else begin
                    ovf_next = 1'b1;
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= PS_NORMAL;
            count_reg <= '0;
            ovf_reg   <= 1'b0;
        end else if (step) begin
            state_reg <= state_next;
            count_reg <= count_next;
            ovf_reg   <= ovf_next;
        end
    end

endmodule
`default_nettype wire
